FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SLDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define SLDC_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (nxt)) \
    else $error(msg);

`endif

FILE: src/sldc_pkg.sv
`timescale 1ns / 1ps

package sldc_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [8:0] HDR_BYTES = 9'd3;
  localparam logic [8:0] SYNC_COUNT = 9'd2;

  localparam int DIV_STEPS = 16;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD      = 2'd2,
    KIND_BADSTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SYNC1 = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } seq_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/sldc_if.sv
`timescale 1ns / 1ps

interface sldc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldc_out_if;
  logic                valid;
  logic                ready;
  sldc_pkg::kind_t     kind;
  logic [7:0]          data_byte;
  logic [7:0]          position;
  logic [7:0]          computed_sum;

  modport source (output valid, output kind, output data_byte, output position,
                  output computed_sum, input ready);
  modport sink (input valid, input kind, input data_byte, input position,
                input computed_sum, output ready);
endinterface

FILE: src/sldc_div.sv
`timescale 1ns / 1ps

module sldc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sldc_pkg::div_ctrl_t ctrl,
  input  logic [15:0]         dividend,
  input  logic [8:0]          divisor,
  output sldc_pkg::div_stat_t stat,
  output logic [7:0]          quotient
);

  logic                       busy_r, done_r;
  logic [sldc_pkg::CNT_W-1:0] cnt_r;
  logic [8:0]                 rem_r, rem_nxt;
  logic [15:0]                quo_r, quo_nxt;
  logic [8:0]                 dsr_r;
  logic [9:0]                 rem_sh, rem_sub;
  logic                       ge, last;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[15]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_sub = rem_sh - {1'b0, dsr_r};
    rem_nxt = ge ? rem_sub[8:0] : rem_sh[8:0];
    quo_nxt = {quo_r[14:0], ge};
    last    = cnt_r == sldc_pkg::CNT_W'(sldc_pkg::DIV_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  // frame sums never exceed 255 times the divisor
  assign quotient  = quo_r[7:0];

endmodule

FILE: src/sync_length_avg_checksum_deframer.sv
// Payload and bad-start results appear in the output register in the cycle after the transfer.
// The checksum byte, or a zero length byte, starts a 16-step divider: its status result is
// loaded once the divider is done and the output register is free; no byte is taken meanwhile.
// Other bytes go at one per cycle; a byte is taken only while the output register is empty or being emptied.
// rst_n is synchronous, active low: frame state cleared, waiting for the first sync byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sync_length_avg_checksum_deframer (
  input logic        clk,
  input logic        rst_n,
  sldc_in_if.sink    in_ch,
  sldc_out_if.source out_ch
);

  sldc_pkg::seq_t      state_r, state_nxt;
  sldc_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]          frame_length_r, frame_length_nxt;
  logic [8:0]          bytes_seen_r, bytes_seen_nxt;
  logic [15:0]         running_sum_r, running_sum_nxt;
  logic [7:0]          chk_r, chk_nxt;

  logic                out_valid_r, out_valid_nxt;
  sldc_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic [7:0]          out_pos_r, out_pos_nxt;
  logic [7:0]          out_avg_r, out_avg_nxt;

  sldc_pkg::div_ctrl_t div_ctrl;
  sldc_pkg::div_stat_t div_stat;
  logic [7:0]          quotient;
  logic [8:0]          divisor;

  logic                slot_free, accept, sync_ok, body_end, frame_end;
  logic [7:0]          b;
  logic [8:0]          seen_inc, pos9;
  logic [15:0]         sum_add;

  sldc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (running_sum_r),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    b         = in_ch.rx_byte;
    slot_free = !out_valid_r || out_ch.ready;
    accept    = in_ch.valid && in_ch.ready;
    sync_ok   = b == sldc_pkg::SYNC_BYTE;
    seen_inc  = bytes_seen_r + 9'd1;
    pos9      = seen_inc - (sldc_pkg::HDR_BYTES + 9'd1);
    body_end  = seen_inc >= (sldc_pkg::HDR_BYTES + {1'b0, frame_length_r});
    sum_add   = running_sum_r + {8'd0, b};
    divisor   = sldc_pkg::SYNC_COUNT + {1'b0, frame_length_r};
    frame_end = ((phase_r == sldc_pkg::PH_LEN) && (b == 8'd0)) ||
                ((phase_r == sldc_pkg::PH_BODY) && body_end);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sldc_pkg::ST_IDLE: if (accept && frame_end) state_nxt = sldc_pkg::ST_DIV;
      sldc_pkg::ST_DIV:  if (div_stat.done) state_nxt = sldc_pkg::ST_EMIT;
      sldc_pkg::ST_EMIT: if (slot_free) state_nxt = sldc_pkg::ST_IDLE;
      default:           state_nxt = sldc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready    = (state_r == sldc_pkg::ST_IDLE) && slot_free;
    div_ctrl.start = accept && frame_end;
  end

  // frame tracking
  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    running_sum_nxt  = running_sum_r;
    chk_nxt          = chk_r;
    if (accept) begin
      if (frame_end || (!sync_ok && (phase_r == sldc_pkg::PH_SYNC1 ||
                                     phase_r == sldc_pkg::PH_SYNC2))) begin
        phase_nxt        = sldc_pkg::PH_SYNC1;
        frame_length_nxt = 8'd0;
        bytes_seen_nxt   = 9'd0;
        running_sum_nxt  = 16'd0;
        if (frame_end) chk_nxt = b;
      end else begin
        unique case (phase_r)
          sldc_pkg::PH_SYNC1: begin
            phase_nxt       = sldc_pkg::PH_SYNC2;
            bytes_seen_nxt  = seen_inc;
            running_sum_nxt = sum_add;
          end
          sldc_pkg::PH_SYNC2: begin
            phase_nxt       = sldc_pkg::PH_LEN;
            bytes_seen_nxt  = seen_inc;
            running_sum_nxt = sum_add;
          end
          sldc_pkg::PH_LEN: begin
            phase_nxt        = sldc_pkg::PH_BODY;
            frame_length_nxt = b;
            bytes_seen_nxt   = sldc_pkg::HDR_BYTES;
            running_sum_nxt  = sum_add;
          end
          sldc_pkg::PH_BODY: begin
            bytes_seen_nxt  = seen_inc;
            running_sum_nxt = sum_add;
          end
          default: phase_nxt = sldc_pkg::PH_SYNC1;
        endcase
      end
    end
  end

  // output register loading
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_pos_nxt   = out_pos_r;
    out_avg_nxt   = out_avg_r;
    priority if (state_r == sldc_pkg::ST_EMIT && slot_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = (quotient == chk_r) ? sldc_pkg::KIND_GOOD : sldc_pkg::KIND_BAD;
      out_data_nxt  = chk_r;
      out_pos_nxt   = 8'd0;
      out_avg_nxt   = quotient;
    end else if (accept && !sync_ok && (phase_r == sldc_pkg::PH_SYNC1 ||
                                        phase_r == sldc_pkg::PH_SYNC2)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sldc_pkg::KIND_BADSTART;
      out_data_nxt  = 8'd0;
      out_pos_nxt   = 8'd0;
      out_avg_nxt   = 8'd0;
    end else if (accept && phase_r == sldc_pkg::PH_BODY && !body_end) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sldc_pkg::KIND_PAYLOAD;
      out_data_nxt  = b;
      out_pos_nxt   = pos9[7:0];
      out_avg_nxt   = 8'd0;
    end else begin
      out_kind_nxt = out_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sldc_pkg::ST_IDLE;
      phase_r        <= sldc_pkg::PH_SYNC1;
      frame_length_r <= 8'd0;
      bytes_seen_r   <= 9'd0;
      running_sum_r  <= 16'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      running_sum_r  <= running_sum_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_pos_r  <= out_pos_nxt;
    out_avg_r  <= out_avg_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.data_byte    = out_data_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.computed_sum = out_avg_r;

  `SLDC_ASSERT_NEXT(a_start_busy, clk, rst_n, div_ctrl.start, div_stat.busy && state_r == sldc_pkg::ST_DIV, "divider not running after checksum byte")
  `SLDC_ASSERT(a_done_in_div, clk, rst_n, div_stat.done |-> state_r == sldc_pkg::ST_DIV, "divider finished outside divide state")
  `SLDC_ASSERT(a_busy_stall, clk, rst_n, div_stat.busy |-> !in_ch.ready, "byte taken during divide")
  `SLDC_ASSERT(a_body_bounds, clk, rst_n, (phase_r == sldc_pkg::PH_BODY) |-> (frame_length_r != 8'd0 && bytes_seen_r < sldc_pkg::HDR_BYTES + {1'b0, frame_length_r}), "body count beyond frame length")

endmodule
